// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files that check themselves
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/crb_pkg.sv
// types and constants of the credit flow receive ring buffer
// no dependencies
package crb_pkg;

  localparam int LEN_W = 6;
  localparam int HELD_W_MAX = 14;
  localparam int CREDIT_W_MAX = 5;

  typedef logic [1:0] crb_kind_t;

  localparam crb_kind_t CMD_BYTE     = 2'd0;
  localparam crb_kind_t CMD_BYTE_END = 2'd1;
  localparam crb_kind_t CMD_READ     = 2'd2;

  typedef struct packed {
    crb_kind_t        kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } crb_cmd_t;

  typedef struct packed {
    logic [HELD_W_MAX-1:0]   held;
    logic [CREDIT_W_MAX-1:0] credits;
  } crb_stat_t;

endpackage

// File: rtl/core/crb_if.sv
// valid/ready channels of the credit flow receive ring buffer
// no dependencies
interface crb_req_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       packet_end;
  logic [5:0] read_len;

  modport source (output valid, action, data_byte, packet_end, read_len, input ready);
  modport sink (input valid, action, data_byte, packet_end, read_len, output ready);
endinterface

interface crb_rsp_if;
  logic       valid;
  logic       ready;
  logic       is_byte;
  logic [7:0] out_byte;
  logic [1:0] grant_count;
  logic [5:0] read_count;
  logic       overflow;
  logic       last;

  modport source (output valid, is_byte, out_byte, grant_count, read_count, overflow, last,
                  input ready);
  modport sink (input valid, is_byte, out_byte, grant_count, read_count, overflow, last,
                output ready);
endinterface

// File: rtl/core/crb_front.sv
// front end: takes input transfers and turns them into commands
// depends on crb_pkg and crb_req_if
module crb_front import crb_pkg::*; #(
  parameter int MAX_READ = 63
) (
  crb_req_if.sink   req,
  input  logic      q_full,
  output logic      push,
  output crb_cmd_t  push_cmd
);

  assign req.ready = !q_full;
  assign push = req.valid && req.ready;

  always_comb begin
    if (req.action) begin
      push_cmd.kind = CMD_READ;
    end else if (req.packet_end) begin
      push_cmd.kind = CMD_BYTE_END;
    end else begin
      push_cmd.kind = CMD_BYTE;
    end
    push_cmd.data = req.data_byte;
    if (req.read_len > LEN_W'(MAX_READ)) begin
      push_cmd.len = LEN_W'(MAX_READ);
    end else begin
      push_cmd.len = req.read_len;
    end
  end

endmodule

// File: rtl/core/crb_cmd_queue.sv
// two-entry command queue between front and back
// depends on crb_pkg
module crb_cmd_queue import crb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  crb_cmd_t push_cmd,
  input  logic     pop,
  output crb_cmd_t head,
  output logic     full,
  output logic     empty
);

  crb_cmd_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/crb_back.sv
// back end: ring store, indices, credit count and result register
// depends on crb_pkg and crb_rsp_if
module crb_back import crb_pkg::*; #(
  parameter int PACKET_BYTES = 128,
  parameter int PACKET_SLOTS = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  crb_cmd_t  head,
  input  logic      q_empty,
  output logic      pop,
  output crb_stat_t stat,
  crb_rsp_if.source rsp
);

  localparam int BUF_LEN = PACKET_SLOTS * PACKET_BYTES;
  localparam int IDX_W = $clog2(BUF_LEN);
  localparam int CR_W = $clog2(PACKET_SLOTS + 1);
  localparam int CMP_W = (IDX_W > LEN_W) ? IDX_W : LEN_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_STATUS = 2'd2;

  logic [7:0]       ring [BUF_LEN];
  logic [7:0]       rdata;
  logic [1:0]       state;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] held;
  logic [CR_W-1:0]  credits;
  logic             ovf_seen;
  logic [LEN_W-1:0] remaining;
  logic [LEN_W-1:0] rcount;

  logic             out_valid;
  logic             o_is_byte;
  logic [7:0]       o_byte;
  logic [1:0]       o_grant;
  logic [LEN_W-1:0] o_count;
  logic             o_ovf;
  logic             o_last;

  logic             out_free;
  logic             out_load;
  logic             ring_full;
  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] wr_inc;
  logic [IDX_W-1:0] rd_inc;
  logic [CMP_W-1:0] held_ext;
  logic [CMP_W-1:0] len_ext;
  logic [LEN_W-1:0] n;
  logic [CR_W-1:0]  slots;
  logic [CR_W-1:0]  grant;

  assign rsp.valid       = out_valid;
  assign rsp.is_byte     = o_is_byte;
  assign rsp.out_byte    = o_byte;
  assign rsp.grant_count = o_grant;
  assign rsp.read_count  = o_count;
  assign rsp.overflow    = o_ovf;
  assign rsp.last        = o_last;

  assign stat.held    = HELD_W_MAX'(held);
  assign stat.credits = CREDIT_W_MAX'(credits);

  assign out_free  = !out_valid || rsp.ready;
  assign out_load  = out_free && ((state == ST_READ) || (state == ST_STATUS));
  assign ring_full = (held == IDX_W'(BUF_LEN - 1));
  assign wr_inc    = (wr_idx == IDX_W'(BUF_LEN - 1)) ? '0 : wr_idx + IDX_W'(1);
  assign rd_inc    = (rd_idx == IDX_W'(BUF_LEN - 1)) ? '0 : rd_idx + IDX_W'(1);
  assign held_ext  = CMP_W'(held);
  assign len_ext   = CMP_W'(head.len);
  assign n         = (held_ext < len_ext) ? LEN_W'(held_ext) : head.len;

  // whole free packet slots, one compare per slot boundary
  always_comb begin
    slots = '0;
    for (int k = 1; k < PACKET_SLOTS; k++) begin
      if (held <= IDX_W'(BUF_LEN - 1 - k * PACKET_BYTES)) begin
        slots = slots + CR_W'(1);
      end
    end
    grant = (slots > credits) ? slots - credits : '0;
  end

  always_comb begin
    pop    = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          unique case (head.kind) inside
            CMD_BYTE, CMD_BYTE_END: mem_we = !ring_full;
            CMD_READ:               mem_re = (n != '0);
            default:                mem_we = 1'b0;
          endcase
        end
      end
      ST_READ: mem_re = out_free && (remaining != '0);
      ST_STATUS: mem_re = 1'b0;
      default: mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wr_idx] <= head.data;
    end
    if (mem_re) begin
      rdata <= ring[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_idx    <= '0;
      rd_idx    <= '0;
      held      <= '0;
      credits   <= CR_W'(PACKET_SLOTS);
      ovf_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            unique case (head.kind) inside
              CMD_BYTE, CMD_BYTE_END: begin
                if (ring_full) begin
                  ovf_seen <= 1'b1;
                end else begin
                  wr_idx <= wr_inc;
                  held   <= held + IDX_W'(1);
                end
                if (head.kind == CMD_BYTE_END) begin
                  if (credits != '0) begin
                    credits <= credits - CR_W'(1);
                  end
                  rcount <= '0;
                  state  <= ST_STATUS;
                end
              end
              CMD_READ: begin
                rcount <= n;
                if (n == '0) begin
                  state <= ST_STATUS;
                end else begin
                  rd_idx    <= rd_inc;
                  held      <= held - IDX_W'(1);
                  remaining <= n - LEN_W'(1);
                  state     <= ST_READ;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_READ: begin
          if (out_free) begin
            o_is_byte <= 1'b1;
            o_byte    <= rdata;
            o_grant   <= 2'd0;
            o_count   <= '0;
            o_ovf     <= 1'b0;
            o_last    <= 1'b0;
            if (remaining != '0) begin
              rd_idx    <= rd_inc;
              held      <= held - IDX_W'(1);
              remaining <= remaining - LEN_W'(1);
            end else begin
              state <= ST_STATUS;
            end
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            o_is_byte <= 1'b0;
            o_byte    <= 8'd0;
            o_grant   <= 2'(grant);
            o_count   <= rcount;
            o_ovf     <= ovf_seen;
            o_last    <= 1'b1;
            credits   <= credits + grant;
            ovf_seen  <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/credit_flow_receive_ring_buffer.sv
// a packet end goes from the command queue through the idle and status states to the
// result register; a read's first byte goes through idle, the ring store read register,
// the read state and the result register, then one byte a cycle while the output is
// taken, then status; a plain byte needs only idle; one sequencer owns the ring store port
// reset: indices, fill and overflow flag clear, credits go to PACKET_SLOTS, ring
// contents are not cleared
`include "assert_macros.svh"

module credit_flow_receive_ring_buffer import crb_pkg::*; #(
  parameter int PACKET_BYTES = 128,
  parameter int PACKET_SLOTS = 2,
  parameter int MAX_READ = 63
) (
  input  logic      clk,
  input  logic      rst,
  crb_req_if.sink   req,
  crb_rsp_if.source rsp
);

  localparam int BUF_LEN = PACKET_SLOTS * PACKET_BYTES;
  localparam logic [HELD_W_MAX-1:0]   HELD_MAX = HELD_W_MAX'(BUF_LEN - 1);
  localparam logic [CREDIT_W_MAX-1:0] CR_MAX   = CREDIT_W_MAX'(PACKET_SLOTS);

  logic      push;
  crb_cmd_t  push_cmd;
  logic      pop;
  crb_cmd_t  head;
  logic      q_full;
  logic      q_empty;
  crb_stat_t stat;
  logic      byte_out;
  logic      byte_clean;

  crb_front #(
    .MAX_READ (MAX_READ)
  ) u_front (
    .req      (req),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  crb_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  crb_back #(
    .PACKET_BYTES (PACKET_BYTES),
    .PACKET_SLOTS (PACKET_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .stat    (stat),
    .rsp     (rsp)
  );

  assign byte_out   = rsp.valid && rsp.is_byte;
  assign byte_clean = !rsp.last && (rsp.grant_count == 2'd0) && !rsp.overflow;

  `ASSERT_ALWAYS(a_held_bound, clk, rst, stat.held <= HELD_MAX, "ring fill past capacity")
  `ASSERT_ALWAYS(a_credit_bound, clk, rst, stat.credits <= CR_MAX, "credits out above slot count")
  `ASSERT_IMPLIES(a_byte_fields, clk, rst, byte_out, byte_clean, "byte result with status fields")

endmodule
